### hdl/p192r_pkg.sv
package p192r_pkg;

  localparam int WORD_W      = 32;
  localparam int POS_W       = 4;
  localparam int RPOS_W      = 3;
  localparam int WORDS_IN    = 12;
  localparam int WORDS_OUT   = 6;
  localparam int STORE_WORDS = WORDS_IN - 1;
  localparam int ACC_W       = WORD_W + 2;
  localparam int CARRY_W     = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [POS_W-1:0]  TRIGGER_POS = 4'd11;
  localparam logic [RPOS_W-1:0] LAST_POS    = 3'd5;
  localparam logic [RPOS_W-1:0] FOLD_LO_POS = 3'd0;
  localparam logic [RPOS_W-1:0] FOLD_HI_POS = 3'd2;

  localparam logic [3:0] SUM_PATTERN [14] = '{
    4'd6, 4'd10, 4'd7, 4'd11, 4'd8, 4'd6, 4'd10,
    4'd9, 4'd7, 4'd11, 4'd10, 4'd8, 4'd11, 4'd9
  };
  localparam int SUM_COUNT  [WORDS_OUT] = '{2, 2, 3, 3, 2, 2};
  localparam int SUM_OFFSET [WORDS_OUT] = '{0, 2, 4, 7, 10, 12};

  typedef logic [WORDS_IN-1:0][WORD_W-1:0] operand_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_in;
    logic [POS_W-1:0]  word_pos;
  } src_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_word;
    logic [RPOS_W-1:0] result_pos;
    logic              result_last;
  } res_word_t;

  typedef struct packed {
    logic     valid;
    operand_t data;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_FOLD1,
    ST_FOLD2,
    ST_EMIT
  } back_state_t;

endpackage

### hdl/p192_fast_reduction.sv
// NIST P-192 fast reduction, word-serial.
// Source channel (src_valid / src_stall / src_data): one 32-bit word of a
// 384-bit product per cycle while src_stall is low, tagged with its position
// 0..11. Positions 0..10 are stored; position 11 snapshots the store with that
// word and queues a reduction. Positions 12..15 are dropped.
// Result channel (res_valid / res_stall / res_data): six 32-bit words, least
// significant first, result_last set on position 5. The value is below 2^192
// and congruent mod p192; no final subtraction of p is made.
// Result words follow one per cycle while res_stall is low.
// The back-end sequencer works through one load, six column-sum steps, two
// six-step carry folds and six emit steps per number, and finishes one number
// before it pops the next from the job queue; words are taken one per cycle
// while the job queue has room, and src_stall rises when it is full.
// A stall on the result channel holds the output word; the queue keeps
// taking input until it fills.
// Reset clears the queue, the sequencer and res_valid; store words are
// undefined until written.
module p192_fast_reduction #(
  parameter int QUEUE_DEPTH = p192r_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  p192r_pkg::src_word_t src_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output p192r_pkg::res_word_t res_data
);

  p192r_pkg::job_t push;
  p192r_pkg::job_t head;
  logic pop;
  logic full;

  assign src_stall = full;

  p192r_front u_front (
    .clk       (clk),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .push      (push)
  );

  p192r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (full)
  );

  p192r_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  a_last_pos : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.result_last == (res_data.result_pos == p192r_pkg::LAST_POS)))
    else $error("result_last does not match position");

  a_first_pos : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> (res_data.result_pos == '0))
    else $error("result sequence does not open at position zero");

  a_next_pos : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res_data.result_last) |=>
      (res_valid && (res_data.result_pos == $past(res_data.result_pos) + 3'd1)))
    else $error("result words not contiguous");

endmodule

### hdl/p192r_front.sv
module p192r_front (
  input  logic                clk,
  input  logic                src_valid,
  input  logic                src_stall,
  input  p192r_pkg::src_word_t src_data,
  output p192r_pkg::job_t     push
);

  logic [p192r_pkg::STORE_WORDS-1:0][p192r_pkg::WORD_W-1:0] store;
  logic accept;

  assign accept = src_valid && !src_stall;

  always_ff @(posedge clk) begin
    if (accept && (src_data.word_pos inside {[4'd0 : p192r_pkg::TRIGGER_POS - 4'd1]})) begin
      store[src_data.word_pos] <= src_data.word_in;
    end
  end

  always_comb begin
    push.valid = accept && (src_data.word_pos == p192r_pkg::TRIGGER_POS);
    push.data  = {src_data.word_in, store};
  end

endmodule

### hdl/p192r_queue.sv
module p192r_queue #(
  parameter int DEPTH = p192r_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  p192r_pkg::job_t  push,
  input  logic             pop,
  output p192r_pkg::job_t  head,
  output logic             full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  p192r_pkg::operand_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_FULL);
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.data;
    end
  end

  always_comb begin
    head.valid = (count != '0);
    head.data  = entries[rd_ptr];
  end

endmodule

### hdl/p192r_back.sv
module p192r_back (
  input  logic                 clk,
  input  logic                 rst,
  input  p192r_pkg::job_t      head,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_stall,
  output p192r_pkg::res_word_t res_data
);

  localparam int AW = p192r_pkg::ACC_W;
  localparam int WW = p192r_pkg::WORD_W;
  localparam int CW = p192r_pkg::CARRY_W;
  localparam int NO = p192r_pkg::WORDS_OUT;

  p192r_pkg::back_state_t state, state_next;

  logic [p192r_pkg::RPOS_W-1:0] step;
  logic [CW-1:0] carry;
  logic [CW-1:0] k;
  logic [AW-1:0] cs [NO];
  logic [WW-1:0] r [NO];
  logic [AW-1:0] col_sum [NO];
  logic [AW-1:0] acc;
  logic [CW-1:0] fold_add;
  logic last_step;
  logic calc;
  logic emit_go;
  logic out_free;

  for (genvar g = 0; g < NO; g++) begin : g_col
    localparam int OFF = p192r_pkg::SUM_OFFSET[g];
    if (p192r_pkg::SUM_COUNT[g] == 3) begin : g_three
      assign col_sum[g] = {2'b00, head.data[g]}
                        + {2'b00, head.data[p192r_pkg::SUM_PATTERN[OFF]]}
                        + {2'b00, head.data[p192r_pkg::SUM_PATTERN[OFF+1]]}
                        + {2'b00, head.data[p192r_pkg::SUM_PATTERN[OFF+2]]};
    end else begin : g_two
      assign col_sum[g] = {2'b00, head.data[g]}
                        + {2'b00, head.data[p192r_pkg::SUM_PATTERN[OFF]]}
                        + {2'b00, head.data[p192r_pkg::SUM_PATTERN[OFF+1]]};
    end
  end

  assign last_step = (step == p192r_pkg::LAST_POS);
  assign out_free  = !res_valid || !res_stall;
  assign fold_add  = ((step == p192r_pkg::FOLD_LO_POS) || (step == p192r_pkg::FOLD_HI_POS))
                   ? k : '0;

  always_comb begin
    if (state == p192r_pkg::ST_SUM) begin
      acc = cs[0] + {{(AW-CW){1'b0}}, carry};
    end else begin
      acc = {2'b00, r[0]} + {{(AW-CW){1'b0}}, fold_add} + {{(AW-CW){1'b0}}, carry};
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    calc       = 1'b0;
    emit_go    = 1'b0;
    case (state)
      p192r_pkg::ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          state_next = p192r_pkg::ST_SUM;
        end
      end
      p192r_pkg::ST_SUM: begin
        calc = 1'b1;
        if (last_step) state_next = p192r_pkg::ST_FOLD1;
      end
      p192r_pkg::ST_FOLD1: begin
        calc = 1'b1;
        if (last_step) state_next = p192r_pkg::ST_FOLD2;
      end
      p192r_pkg::ST_FOLD2: begin
        calc = 1'b1;
        if (last_step) state_next = p192r_pkg::ST_EMIT;
      end
      p192r_pkg::ST_EMIT: begin
        if (out_free) begin
          emit_go = 1'b1;
          if (last_step) state_next = p192r_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = p192r_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= p192r_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      carry     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        step  <= '0;
        carry <= '0;
      end else if (calc || emit_go) begin
        step <= last_step ? '0 : step + 1'b1;
        if (calc) begin
          carry <= last_step ? '0 : acc[AW-1 -: CW];
        end
      end
      if (emit_go) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NO; i++) begin
        cs[i] <= col_sum[i];
      end
    end else if (state == p192r_pkg::ST_SUM) begin
      for (int i = 0; i < NO - 1; i++) begin
        cs[i] <= cs[i+1];
      end
    end
    if (calc && last_step) begin
      k <= acc[AW-1 -: CW];
    end
    if (calc || emit_go) begin
      for (int i = 0; i < NO - 1; i++) begin
        r[i] <= r[i+1];
      end
      r[NO-1] <= calc ? acc[WW-1:0] : r[0];
    end
    if (emit_go) begin
      res_data.result_word <= r[0];
      res_data.result_pos  <= step;
      res_data.result_last <= last_step;
    end
  end

endmodule

### tb/p192_fast_reduction_chk.sv
`timescale 1ns / 1ps

module p192_fast_reduction_chk
  import p192r_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  input  logic      src_stall,
  input  src_word_t src_data,
  input  logic      res_valid,
  input  logic      res_stall,
  input  res_word_t res_data,
  output int        fail_count,
  output int        words_due
);

  logic [WORD_W-1:0] operand_words [WORDS_IN];
  res_word_t         due_words [$];
  int                shown;

  function automatic void reduce_p192();
    logic [WORD_W-1:0] r [WORDS_OUT];
    logic [63:0]       acc;
    logic [63:0]       k;
    acc = 64'(operand_words[0]) + operand_words[6] + operand_words[10];
    r[0] = acc[31:0];
    acc = (acc >> 32) + operand_words[1] + operand_words[7] + operand_words[11];
    r[1] = acc[31:0];
    acc = (acc >> 32) + operand_words[2] + operand_words[6] + operand_words[8]
        + operand_words[10];
    r[2] = acc[31:0];
    acc = (acc >> 32) + operand_words[3] + operand_words[7] + operand_words[9]
        + operand_words[11];
    r[3] = acc[31:0];
    acc = (acc >> 32) + operand_words[4] + operand_words[8] + operand_words[10];
    r[4] = acc[31:0];
    acc = (acc >> 32) + operand_words[5] + operand_words[9] + operand_words[11];
    r[5] = acc[31:0];
    k = acc >> 32;
    // fold carry above bit 192 back as k*(2^64+1), twice
    repeat (2) begin
      acc = 0;
      for (int i = 0; i < WORDS_OUT; i++) begin
        acc = acc + r[i];
        if (i == FOLD_LO_POS || i == FOLD_HI_POS)
          acc = acc + k;
        r[i] = acc[31:0];
        acc = acc >> 32;
      end
      k = acc;
    end
    for (int i = 0; i < WORDS_OUT; i++)
      due_words.push_back('{result_word: r[i], result_pos: RPOS_W'(i),
                            result_last: (RPOS_W'(i) == LAST_POS)});
  endfunction

  always @(posedge clk) begin
    res_word_t want;
    if (rst) begin
      due_words.delete();
      fail_count <= 0;
      shown = 0;
    end else begin
      if (src_valid && !src_stall && src_data.word_pos < WORDS_IN) begin
        operand_words[src_data.word_pos] = src_data.word_in;
        if (src_data.word_pos == TRIGGER_POS)
          reduce_p192();
      end
      if (res_valid && !res_stall) begin
        if (due_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (shown < 10)
            $display("unexpected result word %h pos %0d last %0b",
                     res_data.result_word, res_data.result_pos, res_data.result_last);
          shown++;
        end else begin
          want = due_words.pop_front();
          if (res_data.result_word !== want.result_word ||
              res_data.result_pos !== want.result_pos ||
              res_data.result_last !== want.result_last) begin
            fail_count <= fail_count + 1;
            if (shown < 10)
              $display("result mismatch: expected %h pos %0d last %0b, got %h pos %0d last %0b",
                       want.result_word, want.result_pos, want.result_last,
                       res_data.result_word, res_data.result_pos, res_data.result_last);
            shown++;
          end
        end
      end
    end
    words_due <= due_words.size();
  end

endmodule

### tb/p192_fast_reduction_tb.sv
`timescale 1ns / 1ps

module p192_fast_reduction_tb;
  import p192r_pkg::*;

  localparam int LIMIT      = 200000;
  localparam int RAND_WORDS = 300;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_LIGHT,
    STALL_HOLD
  } stall_mode_t;

  logic      clk;
  logic      rst;
  logic      src_valid;
  logic      src_stall;
  src_word_t src_data;
  logic      res_valid;
  logic      res_stall;
  res_word_t res_data;
  int        fail_count;
  int        words_due;
  int        cycles;
  int        burst_left;
  int        sent;

  p192_fast_reduction dut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_data (src_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_data (res_data)
  );

  p192_fast_reduction_chk chk (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data),
    .fail_count(fail_count),
    .words_due (words_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    stall_mode_t mode;
    int          run_left;
    res_stall = 1'b0;
    run_left  = 0;
    mode      = STALL_NONE;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        mode     = stall_mode_t'($urandom_range(0, 3));
        run_left = $urandom_range(4, 40);
      end
      run_left--;
      case (mode)
        STALL_NONE:  res_stall <= 1'b0;
        STALL_HALF:  res_stall <= 1'($urandom_range(0, 1));
        STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
        default:     res_stall <= (run_left > 8);
      endcase
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w, input logic [POS_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        src_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    src_valid <= 1'b1;
    src_data  <= '{word_in: w, word_pos: p};
    do @(posedge clk); while (src_stall);
  endtask

  function automatic logic [WORD_W-1:0] pick_word(input bit heavy);
    int roll;
    roll = $urandom_range(0, 7);
    if (heavy && roll < 6)
      return '1;
    case (roll)
      0:       return '0;
      1, 2:    return '1;
      3:       return {16'hFFFF, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic send_number();
    logic [POS_W-1:0] order [WORDS_IN-1];
    logic [POS_W-1:0] t;
    bit               heavy;
    bit               partial;
    int               j;
    heavy   = ($urandom_range(0, 3) == 0);
    partial = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < WORDS_IN - 1; i++)
      order[i] = POS_W'(i);
    if ($urandom_range(0, 1)) begin
      for (int i = WORDS_IN - 2; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int i = 0; i < WORDS_IN - 1; i++) begin
      if (partial && $urandom_range(0, 2) == 0)
        continue;
      if ($urandom_range(0, 15) == 0)
        send_word($urandom, POS_W'($urandom_range(WORDS_IN, 15)));
      send_word(pick_word(heavy), order[i]);
      sent++;
    end
    // drop the trigger now and then to leave an abandoned number
    if ($urandom_range(0, 9) != 0) begin
      send_word(pick_word(heavy), TRIGGER_POS);
      sent++;
      if ($urandom_range(0, 7) == 0) begin
        send_word(pick_word(heavy), TRIGGER_POS);
        sent++;
      end
    end
  endtask

  initial begin
    rst        = 1'b1;
    src_valid  = 1'b0;
    src_data   = '0;
    cycles     = 0;
    burst_left = 0;
    sent       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < WORDS_IN; i++)
      send_word('1, POS_W'(i));
    send_word('0, POS_W'(12));
    send_word('1, POS_W'(13));
    send_word($urandom, POS_W'(14));
    send_word('1, POS_W'(15));
    send_word('0, TRIGGER_POS);
    for (int i = 6; i < WORDS_IN; i++)
      send_word('0, POS_W'(i));

    while (sent < RAND_WORDS)
      send_number();

    @(negedge clk);
    src_valid <= 1'b0;
    while (words_due != 0)
      @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
